>>> sv/allocation_occupancy_histogram_macros.svh
// Assertion helpers for the checker file.
`ifndef ALLOCATION_OCCUPANCY_HISTOGRAM_MACROS_SVH
`define ALLOCATION_OCCUPANCY_HISTOGRAM_MACROS_SVH

// Clocked property, muted while reset is high.
`define AOH_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("aoh assertion failed");

// A stalled beat keeps its value until it is taken.
`define AOH_ASSERT_HOLD(label, clk, rst, vld, rdy, sig) \
   `AOH_ASSERT(label, clk, rst, vld && !rdy |=> $stable(sig))

`endif

>>> sv/aoh_pkg.sv
// ----------------------------------------------------------------------------
// aoh_pkg
// Types, constants and codes of the allocation occupancy histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package aoh_pkg;

   localparam int BUCKETS      = 1024;
   localparam int LIVE_ENTRIES = 256;
   localparam int COLOR_LEVELS = 256;

   localparam int BKT_AW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int LIM_W   = $clog2(BUCKETS + 1);
   localparam int LIVE_AW = (LIVE_ENTRIES > 1) ? $clog2(LIVE_ENTRIES) : 1;
   localparam int SCAN_W  = $clog2(LIVE_ENTRIES + 1);
   localparam int QDEPTH  = 2;
   localparam int QAW     = 1;
   localparam int QCW     = 2;

   localparam int ADDR_W    = 64;
   localparam int BIDX_W    = 10;
   localparam int SHIFT_W   = 6;
   localparam int BCNT_W    = 11;
   localparam int CSR_IDX_W = 3;
   localparam int STATUS_W  = 2;
   localparam int COLOR_W   = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BASE_ADDRESS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_QUANTUM_SHIFT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BUCKET_COUNT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_SAMPLE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PAST_SAMPLE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_STRIDE = 3'd5;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNKNOWN      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL         = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_UNCLASSIFIED = 2'd3;

   typedef enum logic [2:0] {
      OP_READ,
      OP_MALLOC,
      OP_REALLOC,
      OP_FREE,
      OP_NONE
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SEARCH,
      ST_COMMIT,
      ST_WSETUP,
      ST_WSTART,
      ST_WRD,
      ST_WWR,
      ST_BREAD,
      ST_BCOLOR,
      ST_DONE
   } back_state_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  base_address;
      logic [SHIFT_W-1:0] quantum_shift;
      logic [BCNT_W-1:0]  bucket_count;
   } cfg_type;

   typedef struct packed {
      op_type             op;
      logic [ADDR_W-1:0]  old_address;
      logic [ADDR_W-1:0]  request_size;
      logic [ADDR_W-1:0]  new_address;
      logic [BIDX_W-1:0]  bucket_index;
      logic               sample_due;
   } item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                sample_due;
      logic [ADDR_W-1:0]   bucket_bytes;
      logic                bucket_used;
      logic [COLOR_W-1:0]  bucket_color;
   } rsp_type;

   typedef struct packed {
      logic clearing;
   } back_stat_type;

endpackage

`default_nettype wire

>>> sv/aoh_ifs.sv
// ----------------------------------------------------------------------------
// aoh channel interfaces
// Request, response and register write channels, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface aoh_req_if;
   import aoh_pkg::*;
   logic                valid;
   logic                ready;
   logic                func;
   logic [ADDR_W-1:0]   old_address;
   logic [ADDR_W-1:0]   request_size;
   logic [ADDR_W-1:0]   new_address;
   logic [BIDX_W-1:0]   bucket_index;
   modport source (output valid, func, old_address, request_size, new_address,
                   bucket_index, input ready);
   modport sink (input valid, func, old_address, request_size, new_address,
                 bucket_index, output ready);
endinterface

interface aoh_rsp_if;
   import aoh_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                sample_due;
   logic [ADDR_W-1:0]   bucket_bytes;
   logic                bucket_used;
   logic [COLOR_W-1:0]  bucket_color;
   modport source (output valid, status, sample_due, bucket_bytes, bucket_used,
                   bucket_color, input ready);
   modport sink (input valid, status, sample_due, bucket_bytes, bucket_used,
                 bucket_color, output ready);
endinterface

interface aoh_csr_if;
   import aoh_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [ADDR_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/aoh_ram.sv
// ----------------------------------------------------------------------------
// aoh_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module aoh_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  wire logic                                        clock,
   input  wire logic                                        we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                            wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output      logic [WIDTH-1:0]                            rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

`default_nettype wire

>>> sv/aoh_queue.sv
// ----------------------------------------------------------------------------
// aoh_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module aoh_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire aoh_pkg::item_type push_item,
   input  wire logic              pop,
   output      aoh_pkg::item_type head,
   output      logic              full,
   output      logic              empty
);
   import aoh_pkg::*;

   item_type         slot_ff [QDEPTH];
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == QCW'(QDEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end
endmodule

`default_nettype wire

>>> sv/aoh_front.sv
// ----------------------------------------------------------------------------
// aoh_front
// Register file, request intake, event classification and sampling counters.
// ----------------------------------------------------------------------------
`default_nettype none

module aoh_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   aoh_req_if.sink                     req_bus,
   aoh_csr_if.sink                     csr_bus,
   input  wire aoh_pkg::back_stat_type stat,
   input  wire logic                   q_full,
   output      logic                   q_push,
   output      aoh_pkg::item_type      q_item,
   output      aoh_pkg::cfg_type       cfg
);
   import aoh_pkg::*;

   logic [ADDR_W-1:0]  base_ff, first_ff, past_ff, stride_ff;
   logic [SHIFT_W-1:0] shift_ff;
   logic [BCNT_W-1:0]  count_ff;
   logic [ADDR_W-1:0]  event_ff, event_in;
   logic [ADDR_W-1:0]  phase_ff, phase_in;
   logic [ADDR_W-1:0]  stride_eff, phase_inc;
   logic               in_window, due, accept;
   op_type             op;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = !q_full && !stat.clearing;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      if (req_bus.func) begin
         op = OP_READ;
      end else if (req_bus.old_address == '0 && req_bus.new_address != '0) begin
         op = OP_MALLOC;
      end else if (req_bus.old_address != '0 && req_bus.new_address != '0) begin
         op = OP_REALLOC;
      end else if (req_bus.old_address != '0 && req_bus.request_size == '0
                   && req_bus.new_address == '0) begin
         op = OP_FREE;
      end else begin
         op = OP_NONE;
      end
   end

   // sampling window and stride phase
   assign stride_eff = (stride_ff == '0) ? ADDR_W'(1) : stride_ff;
   assign in_window  = (event_ff >= first_ff);
   assign phase_inc  = phase_ff + 1'b1;
   assign due        = in_window && (event_ff < past_ff) && (phase_ff == '0);

   always_comb begin
      event_in = event_ff;
      phase_in = phase_ff;
      if (accept && !req_bus.func) begin
         event_in = event_ff + 1'b1;
         if (in_window) begin
            phase_in = (phase_inc >= stride_eff) ? '0 : phase_inc;
         end
      end
   end

   assign q_push = accept;
   always_comb begin
      q_item.op           = op;
      q_item.old_address  = req_bus.old_address;
      q_item.request_size = req_bus.request_size;
      q_item.new_address  = req_bus.new_address;
      q_item.bucket_index = req_bus.bucket_index;
      q_item.sample_due   = !req_bus.func && due;
   end

   assign cfg.base_address  = base_ff;
   assign cfg.quantum_shift = shift_ff;
   assign cfg.bucket_count  = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         shift_ff  <= '0;
         count_ff  <= BCNT_W'(1024);
         first_ff  <= '0;
         past_ff   <= '1;
         stride_ff <= ADDR_W'(1);
         event_ff  <= '0;
         phase_ff  <= '0;
      end else begin
         event_ff <= event_in;
         phase_ff <= phase_in;
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               REG_BASE_ADDRESS:  base_ff   <= csr_bus.data;
               REG_QUANTUM_SHIFT: shift_ff  <= csr_bus.data[SHIFT_W-1:0];
               REG_BUCKET_COUNT:  count_ff  <= csr_bus.data[BCNT_W-1:0];
               REG_FIRST_SAMPLE:  first_ff  <= csr_bus.data;
               REG_PAST_SAMPLE:   past_ff   <= csr_bus.data;
               REG_SAMPLE_STRIDE: stride_ff <= csr_bus.data;
               default: ;
            endcase
         end
      end
   end
endmodule

`default_nettype wire

>>> sv/aoh_back.sv
// ----------------------------------------------------------------------------
// aoh_back
// Live table search, bucket range walk, bucket read and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module aoh_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire aoh_pkg::cfg_type       cfg,
   input  wire aoh_pkg::item_type      q_item,
   input  wire logic                   q_empty,
   output      logic                   q_pop,
   output      aoh_pkg::rsp_type       rsp_data,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      aoh_pkg::back_stat_type stat
);
   import aoh_pkg::*;

   function automatic logic [COLOR_W-1:0] color_of(input logic [ADDR_W-1:0] count,
                                                   input logic [SHIFT_W-1:0] sh);
      logic [ADDR_W-1:0] v;
      logic [ADDR_W-1:0] m;
      if (sh >= SHIFT_W'(8)) begin
         v = count >> (sh - SHIFT_W'(8));
      end else if (count > ADDR_W'(COLOR_LEVELS)) begin
         v = ADDR_W'(COLOR_LEVELS);   // saturates to the top level below
      end else begin
         v = count << (SHIFT_W'(8) - sh);
      end
      if (v == '0) begin
         return '0;
      end
      m = v - 1'b1;
      return (m > ADDR_W'(255)) ? '1 : m[COLOR_W-1:0];
   endfunction

   back_state_type           state_ff, state_in;
   item_type                 item_ff, item_in;
   logic [BKT_AW-1:0]        clr_ff, clr_in;
   logic [SCAN_W-1:0]        scan_ff, scan_in;
   logic                     cmp_vld_ff, cmp_vld_in;
   logic [LIVE_AW-1:0]       cmp_idx_ff, cmp_idx_in;
   logic                     free_ok_ff, free_ok_in;
   logic [LIVE_AW-1:0]       free_idx_ff, free_idx_in;
   logic [LIVE_AW-1:0]       slot_ff, slot_in;
   logic [ADDR_W-1:0]        len_ff, len_in;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic                     need_add_ff, need_add_in;
   logic [ADDR_W-1:0]        w_addr_ff, w_addr_in;
   logic [ADDR_W-1:0]        w_size_ff, w_size_in;
   logic [ADDR_W-1:0]        w_rel_ff, w_rel_in;
   logic [ADDR_W-1:0]        w_part_ff, w_part_in;
   logic [LIM_W-1:0]         w_idx_ff, w_idx_in;
   logic                     w_first_ff, w_first_in;
   logic                     w_neg_ff, w_neg_in;
   logic                     oob_ff, oob_in;
   logic [ADDR_W-1:0]        bytes_ff, bytes_in;
   logic [COLOR_W-1:0]       color_ff, color_in;
   logic [LIVE_ENTRIES-1:0]  live_vld_ff, live_vld_in;
   logic                     rsp_vld_ff, rsp_vld_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                     bkt_we;
   logic [BKT_AW-1:0]        bkt_waddr, bkt_raddr;
   logic [ADDR_W-1:0]        bkt_wdata, bkt_rdata;
   logic                     live_we;
   logic [LIVE_AW-1:0]       live_waddr, live_raddr;
   logic [2*ADDR_W-1:0]      live_wdata, live_rdata;

   logic [ADDR_W-1:0]        quantum, key, rd_start, rd_len;
   logic [ADDR_W-1:0]        idx_full, offset, head_room, first_part, later_part;
   logic [LIM_W-1:0]         limit;
   logic                     cur_vld, hit, cur_free, scan_end, search_end;
   logic                     start_skip, rd_skip, take;

   aoh_ram #(.WIDTH(ADDR_W), .DEPTH(BUCKETS)) u_bkt_ram (
      .clock (clock),
      .we    (bkt_we),
      .waddr (bkt_waddr),
      .wdata (bkt_wdata),
      .raddr (bkt_raddr),
      .rdata (bkt_rdata)
   );

   // entry layout: length in the upper half, start in the lower half
   aoh_ram #(.WIDTH(2 * ADDR_W), .DEPTH(LIVE_ENTRIES)) u_live_ram (
      .clock (clock),
      .we    (live_we),
      .waddr (live_waddr),
      .wdata (live_wdata),
      .raddr (live_raddr),
      .rdata (live_rdata)
   );

   assign quantum = ADDR_W'(1) << cfg.quantum_shift;
   assign limit   = (32'(cfg.bucket_count) > BUCKETS) ? LIM_W'(BUCKETS)
                                                      : LIM_W'(cfg.bucket_count);

   assign key        = (item_ff.op == OP_MALLOC) ? item_ff.new_address
                                                 : item_ff.old_address;
   assign rd_start   = live_rdata[ADDR_W-1:0];
   assign rd_len     = live_rdata[2*ADDR_W-1:ADDR_W];
   assign cur_vld    = live_vld_ff[cmp_idx_ff];
   assign hit        = cmp_vld_ff && cur_vld && (rd_start == key);
   assign cur_free   = cmp_vld_ff && !cur_vld;
   assign scan_end   = !cmp_vld_ff && (scan_ff == SCAN_W'(LIVE_ENTRIES));
   assign search_end = hit || scan_end;

   assign idx_full   = w_rel_ff >> cfg.quantum_shift;
   assign offset     = w_rel_ff & (quantum - 1'b1);
   assign head_room  = quantum - offset;
   assign first_part = (head_room > w_size_ff) ? w_size_ff : head_room;
   assign later_part = (w_size_ff > quantum) ? quantum : w_size_ff;
   assign start_skip = (w_size_ff == '0) || (idx_full >= ADDR_W'(limit));
   assign rd_skip    = !w_first_ff && ((w_size_ff == '0) || (w_idx_ff >= limit));

   assign take = !q_empty && !rsp_vld_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == BKT_AW'(BUCKETS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (take) begin
               case (q_item.op)
                  OP_READ: state_in = ST_BREAD;
                  OP_NONE: state_in = ST_DONE;
                  default: state_in = ST_SEARCH;
               endcase
            end
         end
         ST_SEARCH: begin
            if (search_end) begin
               if (hit || (item_ff.op == OP_MALLOC && free_ok_ff)) begin
                  state_in = ST_COMMIT;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_COMMIT: state_in = ST_WSETUP;
         ST_WSETUP: state_in = ST_WSTART;
         ST_WSTART: begin
            if (!start_skip) begin
               state_in = ST_WRD;
            end else begin
               state_in = (w_neg_ff && need_add_ff) ? ST_WSETUP : ST_DONE;
            end
         end
         ST_WRD: begin
            if (!rd_skip) begin
               state_in = ST_WWR;
            end else begin
               state_in = (w_neg_ff && need_add_ff) ? ST_WSETUP : ST_DONE;
            end
         end
         ST_WWR:    state_in = ST_WRD;
         ST_BREAD:  state_in = ST_BCOLOR;
         ST_BCOLOR: state_in = ST_DONE;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      item_in     = item_ff;
      clr_in      = clr_ff;
      scan_in     = scan_ff;
      cmp_vld_in  = cmp_vld_ff;
      cmp_idx_in  = cmp_idx_ff;
      free_ok_in  = free_ok_ff;
      free_idx_in = free_idx_ff;
      slot_in     = slot_ff;
      len_in      = len_ff;
      status_in   = status_ff;
      need_add_in = need_add_ff;
      w_addr_in   = w_addr_ff;
      w_size_in   = w_size_ff;
      w_rel_in    = w_rel_ff;
      w_part_in   = w_part_ff;
      w_idx_in    = w_idx_ff;
      w_first_in  = w_first_ff;
      w_neg_in    = w_neg_ff;
      oob_in      = oob_ff;
      bytes_in    = bytes_ff;
      color_in    = color_ff;
      live_vld_in = live_vld_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_ready;
      rsp_in      = rsp_ff;
      q_pop       = 1'b0;
      bkt_we      = 1'b0;
      bkt_waddr   = w_idx_ff[BKT_AW-1:0];
      bkt_wdata   = w_neg_ff ? bkt_rdata - w_part_ff : bkt_rdata + w_part_ff;
      bkt_raddr   = w_idx_ff[BKT_AW-1:0];
      live_we     = 1'b0;
      live_waddr  = slot_ff;
      live_wdata  = {item_ff.request_size, item_ff.new_address};
      live_raddr  = scan_ff[LIVE_AW-1:0];

      case (state_ff)
         ST_CLEAR: begin
            bkt_we    = 1'b1;
            bkt_waddr = clr_ff;
            bkt_wdata = '0;
            clr_in    = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (take) begin
               q_pop       = 1'b1;
               item_in     = q_item;
               scan_in     = '0;
               cmp_vld_in  = 1'b0;
               free_ok_in  = 1'b0;
               bytes_in    = '0;
               color_in    = '0;
               need_add_in = (q_item.op == OP_MALLOC) || (q_item.op == OP_REALLOC);
               status_in   = (q_item.op == OP_NONE) ? STATUS_UNCLASSIFIED : STATUS_OK;
            end
         end
         ST_SEARCH: begin
            // one entry read per cycle, compared in the next cycle
            if (scan_ff < SCAN_W'(LIVE_ENTRIES)) begin
               scan_in    = scan_ff + 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = scan_ff[LIVE_AW-1:0];
            end else begin
               cmp_vld_in = 1'b0;
            end
            if (cur_free && !free_ok_ff) begin
               free_ok_in  = 1'b1;
               free_idx_in = cmp_idx_ff;
            end
            if (hit) begin
               len_in  = rd_len;
               slot_in = cmp_idx_ff;
            end else if (scan_end) begin
               slot_in = free_idx_ff;
               if (item_ff.op == OP_MALLOC) begin
                  status_in = free_ok_ff ? STATUS_OK : STATUS_FULL;
               end else begin
                  status_in = STATUS_UNKNOWN;
               end
            end
         end
         ST_COMMIT: begin
            live_we              = 1'b1;
            live_vld_in[slot_ff] = (item_ff.op != OP_FREE);
            if (item_ff.op == OP_MALLOC) begin
               w_addr_in = item_ff.new_address;
               w_size_in = item_ff.request_size;
               w_neg_in  = 1'b0;
            end else begin
               w_addr_in = item_ff.old_address;
               w_size_in = len_ff;
               w_neg_in  = 1'b1;
            end
         end
         ST_WSETUP: begin
            w_rel_in = w_addr_ff - cfg.base_address;
         end
         ST_WSTART: begin
            if (!start_skip) begin
               w_idx_in   = idx_full[LIM_W-1:0];
               w_part_in  = first_part;
               w_first_in = 1'b1;
            end else if (w_neg_ff && need_add_ff) begin
               w_addr_in = item_ff.new_address;
               w_size_in = item_ff.request_size;
               w_neg_in  = 1'b0;
            end
         end
         ST_WRD: begin
            if (!rd_skip) begin
               w_first_in = 1'b0;
               if (!w_first_ff) w_part_in = later_part;
            end else if (w_neg_ff && need_add_ff) begin
               w_addr_in = item_ff.new_address;
               w_size_in = item_ff.request_size;
               w_neg_in  = 1'b0;
            end
         end
         ST_WWR: begin
            bkt_we    = 1'b1;
            w_size_in = w_size_ff - w_part_ff;
            w_idx_in  = w_idx_ff + 1'b1;
         end
         ST_BREAD: begin
            bkt_raddr = BKT_AW'(item_ff.bucket_index);
            oob_in    = (32'(item_ff.bucket_index) >= BUCKETS);
         end
         ST_BCOLOR: begin
            bytes_in = oob_ff ? '0 : bkt_rdata;
            color_in = oob_ff ? '0 : color_of(bkt_rdata, cfg.quantum_shift);
         end
         ST_DONE: begin
            rsp_vld_in          = 1'b1;
            rsp_in.status       = status_ff;
            rsp_in.sample_due   = item_ff.sample_due;
            rsp_in.bucket_bytes = bytes_ff;
            rsp_in.bucket_used  = (bytes_ff != '0);
            rsp_in.bucket_color = color_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_ff      <= '0;
         live_vld_ff <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         live_vld_ff <= live_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      scan_ff     <= scan_in;
      cmp_vld_ff  <= cmp_vld_in;
      cmp_idx_ff  <= cmp_idx_in;
      free_ok_ff  <= free_ok_in;
      free_idx_ff <= free_idx_in;
      slot_ff     <= slot_in;
      len_ff      <= len_in;
      status_ff   <= status_in;
      need_add_ff <= need_add_in;
      w_addr_ff   <= w_addr_in;
      w_size_ff   <= w_size_in;
      w_rel_ff    <= w_rel_in;
      w_part_ff   <= w_part_in;
      w_idx_ff    <= w_idx_in;
      w_first_ff  <= w_first_in;
      w_neg_ff    <= w_neg_in;
      oob_ff      <= oob_in;
      bytes_ff    <= bytes_in;
      color_ff    <= color_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_data       = rsp_ff;
   assign stat.clearing  = (state_ff == ST_CLEAR);
endmodule

`default_nettype wire

>>> sv/allocation_occupancy_histogram.sv
// ----------------------------------------------------------------------------
// allocation_occupancy_histogram
// Live allocation table and per-bucket byte occupancy from an allocation trace.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries trace events (func 0) and bucket reads (func 1); every
//   request beat yields exactly one rsp_bus beat, in order. csr_bus writes
//   the six registers and is always ready; write only while the block idles.
//   A trace event scans the live table (one entry per cycle from the entry
//   RAM; a realloc or free stops at the matching entry), commits, then walks
//   each range with a read-modify-write of every bucket touched in the
//   bucket RAM, and responds. A realloc walks twice. A bucket read reads
//   and colours one bucket; an unclassified record goes straight to the
//   response. One item is worked on at a time; a 2-deep queue lets the
//   request side run ahead. After reset the bucket RAM is cleared, one
//   bucket per cycle, with req_bus.ready low.
//   The response is held in a register; while rsp_bus.ready is low the back
//   end waits and the queue then backs up into req_bus.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module allocation_occupancy_histogram (
   input  wire logic clock,
   input  wire logic reset,
   aoh_req_if.sink   req_bus,
   aoh_rsp_if.source rsp_bus,
   aoh_csr_if.sink   csr_bus
);
   import aoh_pkg::*;

   cfg_type       cfg;
   item_type      push_item, head;
   back_stat_type stat;
   rsp_type       rsp_data;
   logic          q_push, q_pop, q_full, q_empty, rsp_valid;

   aoh_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .csr_bus (csr_bus),
      .stat    (stat),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_item  (push_item),
      .cfg     (cfg)
   );

   aoh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head      (head),
      .full      (q_full),
      .empty     (q_empty)
   );

   aoh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_item    (head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat)
   );

   assign rsp_bus.valid        = rsp_valid;
   assign rsp_bus.status       = rsp_data.status;
   assign rsp_bus.sample_due   = rsp_data.sample_due;
   assign rsp_bus.bucket_bytes = rsp_data.bucket_bytes;
   assign rsp_bus.bucket_used  = rsp_data.bucket_used;
   assign rsp_bus.bucket_color = rsp_data.bucket_color;
endmodule

`default_nettype wire

>>> sv/aoh_checker.sv
// ----------------------------------------------------------------------------
// aoh_checker
// Port-level checks on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "allocation_occupancy_histogram_macros.svh"

module aoh_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_status,
   input wire logic        rsp_sample_due,
   input wire logic [63:0] rsp_bucket_bytes,
   input wire logic        rsp_bucket_used,
   input wire logic [7:0]  rsp_bucket_color
);
   import aoh_pkg::*;

   logic used_ok, meta_beat, no_bucket;

   assign used_ok   = (rsp_bucket_used == (rsp_bucket_bytes != '0));
   // trace event beats carry status and sampling, never bucket data
   assign meta_beat = (rsp_status != STATUS_OK) || rsp_sample_due;
   assign no_bucket = (rsp_bucket_bytes == '0) && (rsp_bucket_color == '0);

   `AOH_ASSERT(a_rsp_valid_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `AOH_ASSERT_HOLD(a_rsp_bytes_hold, clock, reset, rsp_valid, rsp_ready, rsp_bucket_bytes)
   `AOH_ASSERT(a_used_matches, clock, reset, rsp_valid |-> used_ok)
   `AOH_ASSERT(a_event_no_bucket, clock, reset, rsp_valid && meta_beat |-> no_bucket)
endmodule

bind allocation_occupancy_histogram aoh_checker u_aoh_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_status       (rsp_bus.status),
   .rsp_sample_due   (rsp_bus.sample_due),
   .rsp_bucket_bytes (rsp_bus.bucket_bytes),
   .rsp_bucket_used  (rsp_bus.bucket_used),
   .rsp_bucket_color (rsp_bus.bucket_color)
);

`default_nettype wire

>>> verif/tb_allocation_occupancy_histogram.sv
// ----------------------------------------------------------------------------
// tb_allocation_occupancy_histogram
// Self-checking bench: a directed opener, then randomized trace phases under
// several register settings and idle patterns. A scoreboard class predicts
// every response beat from its own copy of the live table and the buckets.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_allocation_occupancy_histogram;
   import aoh_pkg::*;

   class occupancy_scoreboard;
      logic [63:0] base_address, first_sample, past_sample, sample_stride;
      logic [5:0]  quantum_shift;
      logic [10:0] bucket_count;
      logic [63:0] occupancy [BUCKETS];
      logic [63:0] live_start [LIVE_ENTRIES];
      logic [63:0] live_length [LIVE_ENTRIES];
      bit          live_valid [LIVE_ENTRIES];
      logic [63:0] event_number, stride_phase;
      rsp_type     pending_rsp [$];
      int          mismatches, checked, n_events, n_reads;
      int          n_status [4];

      function new();
         base_address  = '0;
         quantum_shift = '0;
         bucket_count  = 11'd1024;
         first_sample  = '0;
         past_sample   = '1;
         sample_stride = 64'd1;
         foreach (occupancy[i]) occupancy[i] = '0;
         foreach (live_valid[i]) live_valid[i] = 0;
         event_number = '0;
         stride_phase = '0;
         mismatches = 0;
         checked = 0;
         n_events = 0;
         n_reads = 0;
         foreach (n_status[i]) n_status[i] = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] data);
         case (idx)
            REG_BASE_ADDRESS:  base_address = data;
            REG_QUANTUM_SHIFT: quantum_shift = data[5:0];
            REG_BUCKET_COUNT:  bucket_count = data[10:0];
            REG_FIRST_SAMPLE:  first_sample = data;
            REG_PAST_SAMPLE:   past_sample = data;
            REG_SAMPLE_STRIDE: sample_stride = data;
            default: ;
         endcase
      endfunction

      function logic [63:0] limit_buckets();
         return (bucket_count > BUCKETS) ? 64'(BUCKETS) : 64'(bucket_count);
      endfunction

      function void walk_range(logic [63:0] addr, logic [63:0] size, bit neg);
         logic [63:0] quantum, rel, idx, part, lim;
         quantum = 64'd1 << quantum_shift;
         rel = addr - base_address;
         idx = rel >> quantum_shift;
         lim = limit_buckets();
         if (size == 0 || idx >= lim) return;
         part = quantum - (rel & (quantum - 64'd1));
         if (part > size) part = size;
         forever begin
            if (neg) occupancy[idx] = occupancy[idx] - part;
            else occupancy[idx] = occupancy[idx] + part;
            size = size - part;
            idx = idx + 64'd1;
            if (size == 0 || idx >= lim) break;
            part = (size > quantum) ? quantum : size;
         end
      endfunction

      function int find_live(logic [63:0] addr);
         for (int k = 0; k < LIVE_ENTRIES; k++)
            if (live_valid[k] && live_start[k] == addr) return k;
         return -1;
      endfunction

      function int find_free();
         for (int k = 0; k < LIVE_ENTRIES; k++)
            if (!live_valid[k]) return k;
         return -1;
      endfunction

      function logic [7:0] color_of(logic [63:0] count);
         logic [63:0] v;
         if (quantum_shift >= 8) v = count >> (quantum_shift - 8);
         else if (count > COLOR_LEVELS) return 8'd255;
         else v = count << (8 - quantum_shift);
         if (v == 0) return 8'd0;
         v = v - 64'd1;
         return (v > 255) ? 8'd255 : v[7:0];
      endfunction

      function void note_item(logic func, logic [63:0] oa, logic [63:0] sz,
                              logic [63:0] na, logic [9:0] bi);
         rsp_type     e;
         logic [63:0] stride;
         int          k;
         e = '0;
         if (func) begin
            e.bucket_bytes = occupancy[bi];
            e.bucket_used  = occupancy[bi] != 0;
            e.bucket_color = (occupancy[bi] != 0) ? color_of(occupancy[bi]) : 8'd0;
            n_reads++;
         end else begin
            if (oa == 0 && na != 0) begin
               k = find_live(na);
               if (k < 0) k = find_free();
               if (k < 0) e.status = STATUS_FULL;
               else begin
                  walk_range(na, sz, 0);
                  live_start[k] = na;
                  live_length[k] = sz;
                  live_valid[k] = 1;
               end
            end else if (oa != 0 && na != 0) begin
               k = find_live(oa);
               if (k < 0) e.status = STATUS_UNKNOWN;
               else begin
                  walk_range(oa, live_length[k], 1);
                  walk_range(na, sz, 0);
                  live_start[k] = na;
                  live_length[k] = sz;
               end
            end else if (oa != 0 && sz == 0 && na == 0) begin
               k = find_live(oa);
               if (k < 0) e.status = STATUS_UNKNOWN;
               else begin
                  walk_range(oa, live_length[k], 1);
                  live_valid[k] = 0;
               end
            end else
               e.status = STATUS_UNCLASSIFIED;
            stride = (sample_stride == 0) ? 64'd1 : sample_stride;
            if (event_number >= first_sample) begin
               if (event_number < past_sample && stride_phase == 0) e.sample_due = 1'b1;
               stride_phase = stride_phase + 64'd1;
               if (stride_phase >= stride) stride_phase = '0;
            end
            event_number = event_number + 64'd1;
            n_events++;
            n_status[e.status]++;
         end
         pending_rsp.push_back(e);
      endfunction

      function void check_rsp(rsp_type got);
         rsp_type e;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("error: response beat with none expected");
            return;
         end
         e = pending_rsp.pop_front();
         checked++;
         if (got.status !== e.status || got.sample_due !== e.sample_due ||
             got.bucket_bytes !== e.bucket_bytes || got.bucket_used !== e.bucket_used ||
             got.bucket_color !== e.bucket_color) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("error: beat %0d exp st=%0d due=%0b bytes=%h used=%0b col=%0d",
                        checked, e.status, e.sample_due, e.bucket_bytes, e.bucket_used,
                        e.bucket_color);
               $display("       got st=%0d due=%0b bytes=%h used=%0b col=%0d",
                        got.status, got.sample_due, got.bucket_bytes,
                        got.bucket_used, got.bucket_color);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   idle_mode = 0;   // 0 none, 1 sender, 2 receiver, 3 both
   int   malloc_bias = 35;

   aoh_req_if req_bus();
   aoh_rsp_if rsp_bus();
   aoh_csr_if csr_bus();

   occupancy_scoreboard sb = new();

   allocation_occupancy_histogram u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #5 clock = ~clock;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.func = 1'b0;
      req_bus.old_address = '0;
      req_bus.request_size = '0;
      req_bus.new_address = '0;
      req_bus.bucket_index = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
   end

   // response side: check accepted beats, then pick next ready
   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.status = rsp_bus.status;
         got.sample_due = rsp_bus.sample_due;
         got.bucket_bytes = rsp_bus.bucket_bytes;
         got.bucket_used = rsp_bus.bucket_used;
         got.bucket_color = rsp_bus.bucket_color;
         sb.check_rsp(got);
      end
      if (reset) rsp_bus.ready <= 1'b0;
      else if (idle_mode == 2) rsp_bus.ready <= ($urandom_range(0, 99) >= 45);
      else if (idle_mode == 3) rsp_bus.ready <= ($urandom_range(0, 99) >= 33);
      else rsp_bus.ready <= 1'b1;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // valid stays high across back-to-back beats; lowered for an idle gap or a drain
   task automatic send(logic func, logic [63:0] oa, logic [63:0] sz,
                       logic [63:0] na, logic [9:0] bi);
      int pct;
      pct = (idle_mode == 1) ? 45 : (idle_mode == 3) ? 33 : 0;
      if (pct != 0 && $urandom_range(0, 99) < pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < pct);
      end
      req_bus.valid <= 1'b1;
      req_bus.func <= func;
      req_bus.old_address <= oa;
      req_bus.request_size <= sz;
      req_bus.new_address <= na;
      req_bus.bucket_index <= bi;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_item(func, oa, sz, na, bi);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [63:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= data;
      do @(posedge clock); while (!csr_bus.ready);
      sb.write_reg(idx, data);
   endtask

   task automatic configure(logic [63:0] base, logic [5:0] sh, logic [10:0] cnt,
                            logic [63:0] first, logic [63:0] past, logic [63:0] stride);
      drain();
      csr_write(REG_BASE_ADDRESS, base);
      // junk above the field must be dropped
      csr_write(REG_QUANTUM_SHIFT, {$urandom, 26'h0, sh});
      csr_write(REG_BUCKET_COUNT, 64'(cnt));
      csr_write(REG_FIRST_SAMPLE, first);
      csr_write(REG_PAST_SAMPLE, past);
      csr_write(REG_SAMPLE_STRIDE, stride);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [63:0] pick_addr();
      logic [63:0] lim, bkt;
      lim = sb.limit_buckets();
      if ($urandom_range(0, 99) < 15 || lim == 0) return rand64();
      bkt = 64'($urandom_range(0, int'(lim) - 1));
      return sb.base_address + (bkt << sb.quantum_shift) +
             (rand64() & ((64'd1 << sb.quantum_shift) - 64'd1));
   endfunction

   function automatic logic [63:0] pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)
         return (64'($urandom_range(1, 4)) << sb.quantum_shift) +
                64'($urandom_range(0, 7));
      if (r < 85) return 64'($urandom_range(1, 255));
      if (r < 95) return rand64();
      return 64'd0;
   endfunction

   // a live object's start, or a stray address now and then
   function automatic logic [63:0] pick_old();
      int idx [$];
      for (int k = 0; k < LIVE_ENTRIES; k++) if (sb.live_valid[k]) idx.push_back(k);
      if (idx.size() == 0 || $urandom_range(0, 9) == 0) return rand64() | 64'd1;
      return sb.live_start[idx[$urandom_range(0, idx.size() - 1)]];
   endfunction

   task automatic random_items(int n);
      int r;
      logic [63:0] a;
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 20)
            send(1'b1, rand64(), rand64(), rand64(), 10'($urandom_range(0, 1023)));
         else if (r < 20 + malloc_bias)
            send(1'b0, 64'd0, pick_size(), pick_addr(), 10'($urandom));
         else if (r < 35 + malloc_bias) begin
            a = pick_addr();
            send(1'b0, pick_old(), pick_size(), a, 10'($urandom));
         end else if (r < 92) begin
            a = pick_old();
            send(1'b0, a, 64'd0, 64'd0, 10'($urandom));
         end else
            send(1'b0, ($urandom_range(0, 1) ? rand64() : 64'd0), rand64(),
                 ($urandom_range(0, 1) ? rand64() : 64'd0), 10'($urandom));
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed opener on reset settings
      send(1'b0, 64'd0, 64'd8, 64'h10, 10'd0);
      send(1'b1, 64'd0, 64'd0, 64'd0, 10'h10);
      send(1'b0, 64'h10, 64'd300, 64'h20, 10'd0);
      send(1'b1, 64'd0, 64'd0, 64'd0, 10'h21);
      send(1'b0, 64'h20, 64'd0, 64'd0, 10'd0);
      send(1'b0, 64'h999, 64'd0, 64'd0, 10'd0);
      send(1'b0, 64'h998, 64'd4, 64'h40, 10'd0);
      send(1'b0, 64'd0, 64'd5, 64'd0, 10'd0);
      send(1'b0, 64'h55, 64'd5, 64'd0, 10'd0);
      send(1'b0, 64'd0, 64'd3, 64'h40, 10'd0);
      send(1'b0, 64'd0, 64'd3, 64'h40, 10'd0);
      send(1'b1, 64'd0, 64'd0, 64'd0, 10'h41);
      send(1'b0, 64'd0, 64'd0, 64'h80, 10'd0);
      send(1'b0, 64'd0, '1, '1, 10'd0);
      send(1'b0, 64'd0, 64'd2, 64'h3FF, 10'd0);
      send(1'b1, '1, '1, '1, 10'h3FF);
      send(1'b1, 64'd0, 64'd0, 64'd0, 10'd0);
      random_items(220);

      idle_mode = 1;
      configure(64'h1000_0000, 6'd4, 11'd64, 64'd0, '1, 64'd3);
      send(1'b0, 64'd0, 64'd100, 64'h1000_0005, 10'd0);
      send(1'b1, 64'd0, 64'd0, 64'd0, 10'd1);
      random_items(230);

      idle_mode = 2;
      configure(64'hFFFF_FFFF_0000_0000, 6'd12, 11'd2047, sb.event_number + 64'd10,
                sb.event_number + 64'd150, 64'd0);
      random_items(230);

      // small window and busy mallocs to fill the live table
      idle_mode = 3;
      malloc_bias = 60;
      configure(64'd0, 6'd0, 11'd1, 64'd0, '1, '1);
      random_items(280);

      idle_mode = 0;
      malloc_bias = 35;
      configure(64'h8000_0000_0000_0000, 6'd63, 11'd0, '1, '1, 64'd2);
      random_items(100);

      idle_mode = 3;
      configure(64'h4000, 6'd8, 11'd1024, 64'd0, 64'd0, 64'd7);
      random_items(120);
      configure(64'h4000, 6'd1, 11'd1024, 64'd5, sb.event_number + 64'd60, 64'd7);
      random_items(250);

      drain();
      $display("covered %0d trace events and %0d bucket reads over 7 register settings",
               sb.n_events, sb.n_reads);
      $display("status mix: ok %0d, unknown %0d, full %0d, unclassified %0d",
               sb.n_status[0], sb.n_status[1], sb.n_status[2], sb.n_status[3]);
      if (sb.mismatches == 0 && sb.pending_rsp.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #500_000_000;
      $display("timeout");
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

`default_nettype wire
